### hdl/lpg_pkg.sv
// Package for the long press gesture detector.
// Holds field widths, command and state codes, and the config/result structs.
// No dependencies.
`default_nettype none

package lpg_pkg;

    localparam int POS_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int DEF_DEVICE_ID_BITS   = 8;
    localparam int DEF_SEQUENCE_ID_BITS = 8;
    localparam int DEF_COORD_BITS       = 16;
    localparam int DEF_TIMER_BITS       = 16;

    localparam logic [CFG_W-1:0] MOVE_THRESHOLD_RESET = 16'd32;
    localparam logic [CFG_W-1:0] TRIGGER_DELAY_RESET  = 16'd600;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_DELAY  = 2'd1;

    typedef enum logic [2:0] {
        CMD_BEGIN  = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_END    = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_OTHER  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        GS_NONE           = 2'd0,
        GS_COLLECTING     = 2'd1,
        GS_NOT_RECOGNIZED = 2'd2,
        GS_RECOGNIZED     = 2'd3
    } t_gesture_state;

    typedef struct packed {
        logic [CFG_W-1:0] move_threshold;
        logic [CFG_W-1:0] trigger_delay;
    } t_cfg;

    typedef struct packed {
        logic                    handled;
        t_gesture_state          gesture_state;
        logic                    pressed;
        logic                    ended;
        logic signed [POS_W-1:0] press_x;
        logic signed [POS_W-1:0] press_y;
    } t_result;

endpackage

`default_nettype wire

### hdl/lpg_cfg_regs.sv
// Configuration registers of the long press gesture detector.
// Depends on lpg_pkg for register indexes, widths and reset values.
`default_nettype none

module lpg_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [lpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lpg_pkg::CFG_W-1:0]     i_cfg_data,
    output lpg_pkg::t_cfg                      o_cfg
);
    import lpg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_threshold <= MOVE_THRESHOLD_RESET;
            r_cfg.trigger_delay  <= TRIGGER_DELAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MOVE_THRESHOLD: r_cfg.move_threshold <= i_cfg_data;
                CFG_TRIGGER_DELAY:  r_cfg.trigger_delay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hdl/lpg_core.sv
// Recognizer state and single-pass next-state logic for one event.
// Depends on lpg_pkg for command codes, gesture states and structs.
`default_nettype none

module lpg_core #(
    parameter int DEVICE_ID_BITS   = lpg_pkg::DEF_DEVICE_ID_BITS,
    parameter int SEQUENCE_ID_BITS = lpg_pkg::DEF_SEQUENCE_ID_BITS,
    parameter int COORD_BITS       = lpg_pkg::DEF_COORD_BITS,
    parameter int TIMER_BITS       = lpg_pkg::DEF_TIMER_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_step,
    input  wire logic [2:0]                       i_cmd,
    input  wire logic [DEVICE_ID_BITS-1:0]        i_device_id,
    input  wire logic                             i_has_sequence,
    input  wire logic [SEQUENCE_ID_BITS-1:0]      i_sequence_id,
    input  wire logic signed [lpg_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [lpg_pkg::POS_W-1:0] i_pos_y,
    input  wire lpg_pkg::t_cfg                    i_cfg,
    output lpg_pkg::t_result                      o_result
);
    import lpg_pkg::*;

    localparam int DW = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
    localparam int TW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic                         r_active, n_active;
    logic [DEVICE_ID_BITS-1:0]    r_held_device, n_held_device;
    logic                         r_held_seq_valid, n_held_seq_valid;
    logic [SEQUENCE_ID_BITS-1:0]  r_held_seq, n_held_seq;
    logic signed [COORD_BITS-1:0] r_held_x, n_held_x;
    logic signed [COORD_BITS-1:0] r_held_y, n_held_y;
    logic                         r_timer_running, n_timer_running;
    logic [TIMER_BITS-1:0]        r_elapsed, n_elapsed;
    logic                         r_was_cancelled, n_was_cancelled;
    logic                         r_was_triggered, n_was_triggered;

    logic signed [COORD_BITS-1:0] x_c, y_c;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS:0]          ax, ay;
    logic                         move_far;
    logic [TIMER_BITS-1:0]        ticks_inc;
    logic                         seq_bad;
    t_result                      res;

    // Cut or sign-extend the 16-bit pixel input to the held coordinate width.
    assign x_c = COORD_BITS'(i_pos_x);
    assign y_c = COORD_BITS'(i_pos_y);

    assign dx = (COORD_BITS + 1)'(r_held_x) - (COORD_BITS + 1)'(x_c);
    assign dy = (COORD_BITS + 1)'(r_held_y) - (COORD_BITS + 1)'(y_c);
    assign ax = dx[COORD_BITS] ? (COORD_BITS + 1)'(-dx) : (COORD_BITS + 1)'(dx);
    assign ay = dy[COORD_BITS] ? (COORD_BITS + 1)'(-dy) : (COORD_BITS + 1)'(dy);
    assign move_far = (DW'(ax) > DW'(i_cfg.move_threshold)) ||
                      (DW'(ay) > DW'(i_cfg.move_threshold));

    assign ticks_inc = (r_elapsed != {TIMER_BITS{1'b1}}) ? r_elapsed + 1'b1 : r_elapsed;
    assign seq_bad   = i_has_sequence && (!r_held_seq_valid || (i_sequence_id != r_held_seq));

    always_comb begin
        n_active         = r_active;
        n_held_device    = r_held_device;
        n_held_seq_valid = r_held_seq_valid;
        n_held_seq       = r_held_seq;
        n_held_x         = r_held_x;
        n_held_y         = r_held_y;
        n_timer_running  = r_timer_running;
        n_elapsed        = r_elapsed;
        n_was_cancelled  = r_was_cancelled;
        n_was_triggered  = r_was_triggered;
        res              = '0;

        if (i_cmd == CMD_TICK) begin
            if (r_active && r_timer_running) begin
                n_elapsed = ticks_inc;
                if (TW'(ticks_inc) >= TW'(i_cfg.trigger_delay)) begin
                    n_timer_running = 1'b0;
                    n_was_triggered = 1'b1;
                    res.pressed     = 1'b1;
                    res.press_x     = POS_W'(r_held_x);
                    res.press_y     = POS_W'(r_held_y);
                end
            end
        end else if (r_active && (i_device_id != r_held_device)) begin
            // foreign device: drop the event
        end else if (r_active && seq_bad) begin
            if (r_timer_running) begin
                n_timer_running = 1'b0;
                n_was_cancelled = 1'b1;
            end
        end else begin
            res.handled = 1'b1;
            case (i_cmd)
                CMD_BEGIN: begin
                    n_held_x         = x_c;
                    n_held_y         = y_c;
                    n_active         = 1'b1;
                    n_held_device    = i_device_id;
                    n_held_seq_valid = i_has_sequence;
                    n_held_seq       = i_has_sequence ? i_sequence_id : '0;
                    n_timer_running  = 1'b1;
                    n_elapsed        = '0;
                end
                CMD_UPDATE: begin
                    if (move_far && r_timer_running) begin
                        n_timer_running = 1'b0;
                        n_was_cancelled = 1'b1;
                    end
                end
                CMD_END: begin
                    res.ended        = r_was_triggered;
                    n_active         = 1'b0;
                    n_held_device    = '0;
                    n_held_seq_valid = 1'b0;
                    n_held_seq       = '0;
                    n_held_x         = '1;
                    n_held_y         = '1;
                    n_timer_running  = 1'b0;
                    n_elapsed        = '0;
                    n_was_cancelled  = 1'b0;
                    n_was_triggered  = 1'b0;
                end
                default: res.handled = 1'b0;
            endcase
        end

        if (!n_active)            res.gesture_state = GS_NONE;
        else if (n_timer_running) res.gesture_state = GS_COLLECTING;
        else if (n_was_cancelled) res.gesture_state = GS_NOT_RECOGNIZED;
        else if (n_was_triggered) res.gesture_state = GS_RECOGNIZED;
        else                      res.gesture_state = GS_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active         <= 1'b0;
            r_held_device    <= '0;
            r_held_seq_valid <= 1'b0;
            r_held_seq       <= '0;
            r_held_x         <= '1;
            r_held_y         <= '1;
            r_timer_running  <= 1'b0;
            r_elapsed        <= '0;
            r_was_cancelled  <= 1'b0;
            r_was_triggered  <= 1'b0;
        end else if (i_step) begin
            r_active         <= n_active;
            r_held_device    <= n_held_device;
            r_held_seq_valid <= n_held_seq_valid;
            r_held_seq       <= n_held_seq;
            r_held_x         <= n_held_x;
            r_held_y         <= n_held_y;
            r_timer_running  <= n_timer_running;
            r_elapsed        <= n_elapsed;
            r_was_cancelled  <= n_was_cancelled;
            r_was_triggered  <= n_was_triggered;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

### hdl/long_press_gesture_detector.sv
// Long press gesture detector: input register, recognizer core, result register.
// An event passes through the input register and then the result register.
// Throughput: one event per cycle unless stalled; the state updates in a single pass per event.
// Stall on the result side backs up into the input register, then into o_in_stall.
// Reset (synchronous, active low) clears the recognizer, empties both registers and
// loads move_threshold 32 and trigger_delay 600.
`default_nettype none

module long_press_gesture_detector #(
    parameter int DEVICE_ID_BITS   = lpg_pkg::DEF_DEVICE_ID_BITS,
    parameter int SEQUENCE_ID_BITS = lpg_pkg::DEF_SEQUENCE_ID_BITS,
    parameter int COORD_BITS       = lpg_pkg::DEF_COORD_BITS,
    parameter int TIMER_BITS       = lpg_pkg::DEF_TIMER_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // event channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [2:0]                       i_cmd,
    input  wire logic [DEVICE_ID_BITS-1:0]        i_device_id,
    input  wire logic                             i_has_sequence,
    input  wire logic [SEQUENCE_ID_BITS-1:0]      i_sequence_id,
    input  wire logic signed [lpg_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [lpg_pkg::POS_W-1:0] i_pos_y,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_handled,
    output logic [1:0]                            o_gesture_state,
    output logic                                  o_pressed,
    output logic                                  o_ended,
    output logic signed [lpg_pkg::POS_W-1:0]      o_press_x,
    output logic signed [lpg_pkg::POS_W-1:0]      o_press_y,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lpg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lpg_pkg::CFG_W-1:0]        i_cfg_data
);
    import lpg_pkg::*;

    logic                        r_in_valid;
    logic [2:0]                  r_cmd;
    logic [DEVICE_ID_BITS-1:0]   r_device_id;
    logic                        r_has_sequence;
    logic [SEQUENCE_ID_BITS-1:0] r_sequence_id;
    logic signed [POS_W-1:0]     r_pos_x, r_pos_y;

    logic    r_out_valid;
    t_result r_res;
    t_result core_res;
    t_cfg    cfg;
    logic    out_adv;
    logic    step;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;
    assign o_cfg_ready = 1'b1;

    lpg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpg_core #(
        .DEVICE_ID_BITS   (DEVICE_ID_BITS),
        .SEQUENCE_ID_BITS (SEQUENCE_ID_BITS),
        .COORD_BITS       (COORD_BITS),
        .TIMER_BITS       (TIMER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_cmd          (r_cmd),
        .i_device_id    (r_device_id),
        .i_has_sequence (r_has_sequence),
        .i_sequence_id  (r_sequence_id),
        .i_pos_x        (r_pos_x),
        .i_pos_y        (r_pos_y),
        .i_cfg          (cfg),
        .o_result       (core_res)
    );

    // input register: load on every transfer, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd          <= i_cmd;
            r_device_id    <= i_device_id;
            r_has_sequence <= i_has_sequence;
            r_sequence_id  <= i_sequence_id;
            r_pos_x        <= i_pos_x;
            r_pos_y        <= i_pos_y;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_handled       = r_res.handled;
    assign o_gesture_state = r_res.gesture_state;
    assign o_pressed       = r_res.pressed;
    assign o_ended         = r_res.ended;
    assign o_press_x       = r_res.press_x;
    assign o_press_y       = r_res.press_y;

    a_press_xor_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_pressed && o_ended))
        else $error("pressed and ended in one result");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_pressed) |-> (o_press_x == '0 && o_press_y == '0))
        else $error("press position set without pressed");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ended) |-> (o_gesture_state == GS_NONE && o_handled))
        else $error("ended result without cleared state");

    a_press_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pressed) |-> !o_handled)
        else $error("pressed reported on a handled event");

endmodule

`default_nettype wire

### bench/tb_long_press_gesture_detector.sv
// Self-checking bench for long_press_gesture_detector: directed table, then random gestures.
// Checks each result in order against its table entry or a behavioral recognizer model.
// Depends on lpg_pkg and the long_press_gesture_detector RTL.
`timescale 1ns / 1ps

module tb_long_press_gesture_detector;

    import lpg_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 7;

    typedef struct packed {
        logic [2:0]              cmd;
        logic [7:0]              dev;
        logic                    has_seq;
        logic [7:0]              seq;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } t_touch_ev;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_W-1:0]     cfg_val;
        t_touch_ev            ev;
        logic                 typed;
        t_result              want;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [2:0] i_cmd = '0;
    logic [7:0] i_device_id = '0;
    logic i_has_sequence = 1'b0;
    logic [7:0] i_sequence_id = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_handled;
    logic [1:0] o_gesture_state;
    logic o_pressed;
    logic o_ended;
    logic signed [POS_W-1:0] o_press_x;
    logic signed [POS_W-1:0] o_press_y;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    long_press_gesture_detector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_device_id     (i_device_id),
        .i_has_sequence  (i_has_sequence),
        .i_sequence_id   (i_sequence_id),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_handled       (o_handled),
        .o_gesture_state (o_gesture_state),
        .o_pressed       (o_pressed),
        .o_ended         (o_ended),
        .o_press_x       (o_press_x),
        .o_press_y       (o_press_y),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // recognizer model state and its copy of the registers
    logic [CFG_W-1:0] cfg_thresh;
    logic [CFG_W-1:0] cfg_delay;
    logic hold_active;
    logic [7:0] hold_dev;
    logic hold_seq_ok;
    logic [7:0] hold_seq;
    logic signed [POS_W-1:0] hold_x;
    logic signed [POS_W-1:0] hold_y;
    logic timing;
    logic [15:0] tick_count;
    logic cancelled;
    logic fired;

    t_result expected_results[$];
    t_step_row press_steps[$];
    t_result want_res;
    int errors = 0;
    int items_sent = 0;
    int cycles = 0;
    bit in_calm = 1'b0;
    int rx_quiet = 0;
    int rx_busy = 0;
    int rx_pick;

    function automatic void clear_press_hold();
        hold_active = 1'b0;
        hold_dev = '0;
        hold_seq_ok = 1'b0;
        hold_seq = '0;
        hold_x = -16'sd1;
        hold_y = -16'sd1;
        timing = 1'b0;
        tick_count = '0;
        cancelled = 1'b0;
        fired = 1'b0;
    endfunction

    function automatic void stop_press_timer();
        if (timing) begin
            timing = 1'b0;
            cancelled = 1'b1;
        end
    endfunction

    function automatic t_result predict_press(input t_touch_ev ev);
        t_result r;
        int dx, dy;
        r = '0;
        if (ev.cmd == CMD_TICK) begin
            if (hold_active && timing) begin
                if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
                if (tick_count >= cfg_delay) begin
                    timing = 1'b0;
                    fired = 1'b1;
                    r.pressed = 1'b1;
                    r.press_x = hold_x;
                    r.press_y = hold_y;
                end
            end
        end else if (hold_active && ev.dev != hold_dev) begin
            // foreign device: drop silently
        end else if (hold_active && ev.has_seq && (!hold_seq_ok || ev.seq != hold_seq)) begin
            stop_press_timer();
        end else begin
            r.handled = 1'b1;
            case (ev.cmd)
                CMD_BEGIN: begin
                    hold_x = ev.x;
                    hold_y = ev.y;
                    hold_active = 1'b1;
                    hold_dev = ev.dev;
                    hold_seq_ok = ev.has_seq;
                    hold_seq = ev.has_seq ? ev.seq : 8'd0;
                    timing = 1'b1;
                    tick_count = '0;
                end
                CMD_UPDATE: begin
                    dx = int'(hold_x) - int'(ev.x);
                    dy = int'(hold_y) - int'(ev.y);
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    if (dx > int'(cfg_thresh) || dy > int'(cfg_thresh)) stop_press_timer();
                end
                CMD_END: begin
                    r.ended = fired;
                    clear_press_hold();
                end
                default: r.handled = 1'b0;
            endcase
        end
        r.gesture_state = GS_NONE;
        if (hold_active) begin
            if (timing) r.gesture_state = GS_COLLECTING;
            else if (cancelled) r.gesture_state = GS_NOT_RECOGNIZED;
            else if (fired) r.gesture_state = GS_RECOGNIZED;
        end
        return r;
    endfunction

    function automatic t_result res(bit h, t_gesture_state st, bit p, bit e, int px, int py);
        t_result r;
        r.handled = h;
        r.gesture_state = st;
        r.pressed = p;
        r.ended = e;
        r.press_x = 16'(px);
        r.press_y = 16'(py);
        return r;
    endfunction

    function automatic t_step_row touch_row(t_cmd c, int d, bit hs, int s, int x, int y,
                                            bit typed, t_result want);
        t_step_row row;
        row = '0;
        row.ev.cmd = c;
        row.ev.dev = 8'(d);
        row.ev.has_seq = hs;
        row.ev.seq = 8'(s);
        row.ev.x = 16'(x);
        row.ev.y = 16'(y);
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic t_step_row cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
        t_step_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = 16'(val);
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_touch(input t_touch_ev ev, input bit typed, input t_result want);
        int gap;
        t_result pred;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cmd <= ev.cmd;
        i_device_id <= ev.dev;
        i_has_sequence <= ev.has_seq;
        i_sequence_id <= ev.seq;
        i_pos_x <= ev.x;
        i_pos_y <= ev.y;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_press(ev);
        expected_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // registers change only once every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MOVE_THRESHOLD) cfg_thresh = val;
        else cfg_delay = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        t_touch_ev ev;
        ev.cmd = 3'($urandom_range(0, 7));
        ev.dev = 8'($urandom);
        ev.has_seq = 1'($urandom);
        ev.seq = 8'($urandom);
        ev.x = 16'($urandom);
        ev.y = 16'($urandom);
        send_touch(ev, 1'b0, '0);
    endtask

    // one touch from begin to end, with ticks, moves and interference mixed in
    task automatic run_gesture();
        t_touch_ev base, ev;
        int steps, r, t;
        base.cmd = CMD_BEGIN;
        base.dev = 8'($urandom);
        base.has_seq = ($urandom_range(0, 3) != 0);
        base.seq = 8'($urandom);
        base.x = 16'($urandom);
        base.y = 16'($urandom);
        in_calm = ($urandom_range(0, 3) == 0);
        send_touch(base, 1'b0, '0);
        t = int'(cfg_thresh);
        steps = $urandom_range(1, (cfg_delay < 16 ? int'(cfg_delay) : 16) + 6);
        for (int i = 0; i < steps; i++) begin
            ev = base;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                ev.cmd = CMD_TICK;
                ev.dev = 8'($urandom);
                ev.x = 16'($urandom);
            end else if (r < 75) begin
                ev.cmd = CMD_UPDATE;
                ev.x = 16'(int'(base.x) + int'($urandom_range(0, 2 * t + 2)) - t - 1);
                if ($urandom_range(0, 1) == 0)
                    ev.y = 16'(int'(base.y) + int'($urandom_range(0, 2 * t + 2)) - t - 1);
            end else if (r < 80) begin
                ev.cmd = 3'($urandom_range(0, 7));
                ev.dev = base.dev ^ 8'($urandom_range(1, 255));
            end else if (r < 85) begin
                ev.cmd = 3'($urandom_range(0, 7));
                ev.has_seq = 1'b1;
                ev.seq = base.has_seq ? base.seq ^ 8'($urandom_range(1, 255)) : 8'($urandom);
            end else if (r < 90) begin
                ev.cmd = 3'($urandom_range(4, 7));
            end else if (r < 95) begin
                base.x = 16'($urandom);
                base.y = 16'($urandom);
                ev = base;
            end else begin
                ev.cmd = CMD_UPDATE;
                ev.has_seq = 1'b0;
                ev.seq = 8'($urandom);
            end
            send_touch(ev, 1'b0, '0);
        end
        if ($urandom_range(0, 9) != 0) begin
            ev = base;
            ev.cmd = CMD_END;
            send_touch(ev, 1'b0, '0);
        end
        in_calm = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: random stall runs, with quiet stretches now and then
    always @(negedge i_clk) begin
        if (rx_quiet > 0) begin
            rx_quiet--;
            i_out_stall <= 1'b0;
        end else if (rx_busy > 0) begin
            rx_busy--;
            i_out_stall <= 1'b1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 5) rx_quiet = $urandom_range(50, 200);
            else if (rx_pick < 80) rx_busy = 0;
            else if (rx_pick < 96) rx_busy = $urandom_range(1, 3);
            else rx_busy = $urandom_range(10, 40);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual handled %0d state %0d",
                         $time, o_handled, o_gesture_state);
                errors++;
            end else begin
                want_res = expected_results.pop_front();
                check_field("handled", want_res.handled, o_handled);
                check_field("gesture_state", want_res.gesture_state, o_gesture_state);
                check_field("pressed", want_res.pressed, o_pressed);
                check_field("ended", want_res.ended, o_ended);
                check_field("press_x", want_res.press_x, o_press_x);
                check_field("press_y", want_res.press_y, o_press_y);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_long_press_gesture_detector failed");
            $finish;
        end
    end

    initial begin
        t_step_row row;
        int quota, stop_at;
        logic [CFG_W-1:0] thr, dly;

        clear_press_hold();
        cfg_thresh = MOVE_THRESHOLD_RESET;
        cfg_delay = TRIGGER_DELAY_RESET;

        // reset values of the registers apply here
        press_steps.push_back(touch_row(CMD_TICK, 0, 0, 0, 0, 0, 1, res(0, GS_NONE, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_END, 0, 0, 0, 0, 0, 1, res(1, GS_NONE, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_UPDATE, 5, 0, 0, 100, 0, 1,
                                        res(1, GS_NONE, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_OTHER, 9, 1, 3, 0, 0, 1, res(0, GS_NONE, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_BEGIN, 255, 1, 255, 32767, -32768, 1,
                                        res(1, GS_COLLECTING, 0, 0, 0, 0)));
        // movement exactly at the threshold keeps the timer
        press_steps.push_back(touch_row(CMD_UPDATE, 255, 1, 255, 32735, -32736, 1,
                                        res(1, GS_COLLECTING, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_UPDATE, 0, 1, 255, 0, 0, 1,
                                        res(0, GS_COLLECTING, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_UPDATE, 255, 1, 0, 32767, -32768, 1,
                                        res(0, GS_NOT_RECOGNIZED, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_BEGIN, 255, 1, 255, 0, 0, 1,
                                        res(1, GS_COLLECTING, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_UPDATE, 255, 0, 0, 33, 0, 1,
                                        res(1, GS_NOT_RECOGNIZED, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_TICK, 255, 0, 0, 0, 0, 1,
                                        res(0, GS_NOT_RECOGNIZED, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_END, 255, 0, 0, 0, 0, 1, res(1, GS_NONE, 0, 0, 0, 0)));
        // zero delay fires on the first tick
        press_steps.push_back(cfg_row(CFG_MOVE_THRESHOLD, 0));
        press_steps.push_back(cfg_row(CFG_TRIGGER_DELAY, 0));
        press_steps.push_back(touch_row(CMD_BEGIN, 0, 0, 0, -32768, 32767, 1,
                                        res(1, GS_COLLECTING, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_TICK, 0, 0, 0, 0, 0, 1,
                                        res(0, GS_RECOGNIZED, 1, 0, -32768, 32767)));
        press_steps.push_back(touch_row(CMD_UPDATE, 0, 1, 7, 0, 0, 1,
                                        res(0, GS_RECOGNIZED, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_UPDATE, 0, 0, 0, -32768, 32767, 1,
                                        res(1, GS_RECOGNIZED, 0, 0, 0, 0)));
        press_steps.push_back(touch_row(CMD_END, 0, 0, 0, 0, 0, 1, res(1, GS_NONE, 0, 1, 0, 0)));
        press_steps.push_back(cfg_row(CFG_MOVE_THRESHOLD, 65535));
        press_steps.push_back(cfg_row(CFG_TRIGGER_DELAY, 3));
        press_steps.push_back(touch_row(CMD_BEGIN, 42, 1, 1, -32768, -32768, 0, '0));
        press_steps.push_back(touch_row(CMD_UPDATE, 42, 1, 1, 32767, 32767, 0, '0));
        press_steps.push_back(touch_row(CMD_TICK, 42, 1, 1, 0, 0, 0, '0));
        press_steps.push_back(touch_row(CMD_TICK, 7, 0, 0, 0, 0, 0, '0));
        press_steps.push_back(touch_row(CMD_TICK, 200, 1, 9, 0, 0, 0, '0));
        // restart after firing keeps the fired flag
        press_steps.push_back(touch_row(CMD_BEGIN, 42, 1, 1, 5, -5, 0, '0));
        press_steps.push_back(touch_row(CMD_OTHER, 42, 1, 1, 0, 0, 0, '0));
        press_steps.push_back(touch_row(CMD_END, 42, 1, 1, 0, 0, 0, '0));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (press_steps[i]) begin
            row = press_steps[i];
            if (row.is_cfg) write_reg(row.cfg_idx, row.cfg_val);
            else send_touch(row.ev, row.typed, row.want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quota = 85;
            if (p == 0) begin
                thr = 16'hFFFF;
                dly = 16'hFFFF;
                quota = 40;
            end else if (p == 1) begin
                thr = '0;
                dly = 16'd1;
            end else begin
                thr = 16'($urandom_range(0, 48));
                dly = 16'($urandom_range(0, 12));
            end
            write_reg(CFG_MOVE_THRESHOLD, thr);
            write_reg(CFG_TRIGGER_DELAY, dly);
            stop_at = items_sent + quota;
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else run_gesture();
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("tb_long_press_gesture_detector passed");
        else
            $display("tb_long_press_gesture_detector failed");
        $finish;
    end

endmodule

### long_press_gesture_detector.f
hdl/lpg_pkg.sv
hdl/lpg_cfg_regs.sv
hdl/lpg_core.sv
hdl/long_press_gesture_detector.sv
bench/tb_long_press_gesture_detector.sv
